### design/nced_pkg.sv
package nced_pkg;

    // default digit limit of one entity
    localparam int MAX_DIGITS_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECODE_ENTITIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODES    = 2'd1;

    // character codes
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_X_LOWER = 8'h78;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_A_UPPER = 8'h41;
    localparam logic [7:0] CH_F_UPPER = 8'h46;
    localparam logic [7:0] CH_A_LOWER = 8'h61;
    localparam logic [7:0] CH_F_LOWER = 8'h66;

    // longest run of plain bytes one beat can cause (six-byte utf-8 form)
    localparam int DIR_MAX = 6;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_AMP,
        MODE_ENT_START,
        MODE_ENT,
        MODE_ESC0,
        MODE_ESC1
    } t_mode;

    typedef enum logic [1:0] {
        PH_AMP,
        PH_X,
        PH_DIG,
        PH_DIR
    } t_ephase;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hexval;

    typedef struct packed {
        logic [2:0]                cnt;
        logic [DIR_MAX-1:0][7:0]   bytes;
    } t_direct;

    // what one accepted beat has to put out: optional failed entity, then plain bytes
    typedef struct packed {
        logic    flush;
        logic    flush_hex;
        t_direct dir;
    } t_plan;

    function automatic t_hexval hex_value(input logic [7:0] b);
        t_hexval h;
        h = '0;
        if (b inside {[CH_0:CH_9]}) begin
            h.ok  = 1'b1;
            h.val = 4'(b - CH_0);
        end else if (b inside {[CH_A_UPPER:CH_F_UPPER]}) begin
            h.ok  = 1'b1;
            h.val = 4'(b - (CH_A_UPPER - 8'd10));
        end else if (b inside {[CH_A_LOWER:CH_F_LOWER]}) begin
            h.ok  = 1'b1;
            h.val = 4'(b - (CH_A_LOWER - 8'd10));
        end
        return h;
    endfunction

    // utf-8 form of a code, bit 31 dropped above the five-byte range
    function automatic t_direct utf8_encode(input logic [31:0] c);
        t_direct d;
        d = '0;
        if (c < 32'h80) begin
            d.cnt      = 3'd1;
            d.bytes[0] = c[7:0];
        end else if (c < 32'h800) begin
            d.cnt      = 3'd2;
            d.bytes[0] = {3'b110, c[10:6]};
            d.bytes[1] = {2'b10, c[5:0]};
        end else if (c < 32'h10000) begin
            d.cnt      = 3'd3;
            d.bytes[0] = {4'b1110, c[15:12]};
            d.bytes[1] = {2'b10, c[11:6]};
            d.bytes[2] = {2'b10, c[5:0]};
        end else if (c < 32'h200000) begin
            d.cnt      = 3'd4;
            d.bytes[0] = {5'b11110, c[20:18]};
            d.bytes[1] = {2'b10, c[17:12]};
            d.bytes[2] = {2'b10, c[11:6]};
            d.bytes[3] = {2'b10, c[5:0]};
        end else if (c < 32'h4000000) begin
            d.cnt      = 3'd5;
            d.bytes[0] = {6'b111110, c[25:24]};
            d.bytes[1] = {2'b10, c[23:18]};
            d.bytes[2] = {2'b10, c[17:12]};
            d.bytes[3] = {2'b10, c[11:6]};
            d.bytes[4] = {2'b10, c[5:0]};
        end else begin
            d.cnt      = 3'd6;
            d.bytes[0] = {7'b1111110, c[30]};
            d.bytes[1] = {2'b10, c[29:24]};
            d.bytes[2] = {2'b10, c[23:18]};
            d.bytes[3] = {2'b10, c[17:12]};
            d.bytes[4] = {2'b10, c[11:6]};
            d.bytes[5] = {2'b10, c[5:0]};
        end
        return d;
    endfunction

endpackage

### design/nced_if.sv
// text byte channel into the block
interface nced_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, in_byte, end_of_text, input ready);
    modport sink (input valid, in_byte, end_of_text, output ready);
endinterface

// decoded byte channel out of the block
interface nced_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, out_byte, run_last, input ready);
    modport sink (input valid, out_byte, run_last, output ready);
endinterface

// register write channel
interface nced_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [nced_pkg::CFG_IDX_W-1:0]  index;
    logic [nced_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### design/nced_ram.sv
module nced_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/nced_parser.sv
module nced_parser #(
    parameter int MAX_DIGITS = nced_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    nced_in_if.sink                         i_in,
    nced_cfg_if.sink                        i_cfg,
    input  logic                            i_load_ready,
    output logic                            o_load,
    output nced_pkg::t_plan                 o_plan,
    output logic [$clog2(MAX_DIGITS+1)-1:0] o_fcnt,
    output logic                            o_we,
    output logic [$clog2(MAX_DIGITS)-1:0]   o_waddr,
    output logic [7:0]                      o_wdata
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int AW = $clog2(MAX_DIGITS);

    logic r_decode_ent;
    logic r_escape;

    nced_pkg::t_mode r_mode, n_mode;
    logic            r_hex, n_hex;
    logic [31:0]     r_acc, n_acc;
    logic [CW-1:0]   r_cnt, n_cnt;

    logic            beat;
    nced_pkg::t_plan plan;
    logic [CW-1:0]   fcnt;
    logic            wr;

    assign i_in.ready  = i_load_ready;
    assign i_cfg.ready = 1'b1;
    assign beat        = i_in.valid && i_in.ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_ent <= 1'b0;
            r_escape     <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.index == nced_pkg::CFG_DECODE_ENTITIES) begin
                r_decode_ent <= i_cfg.data[0];
            end
            if (i_cfg.index == nced_pkg::CFG_ESCAPE_CODES) begin
                r_escape <= i_cfg.data[0];
            end
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= nced_pkg::MODE_IDLE;
            r_hex  <= 1'b0;
            r_acc  <= '0;
            r_cnt  <= '0;
        end else if (beat) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
        end
    end

    // next parse state and output plan for the beat on the input
    always_comb begin
        logic [7:0]        b;
        nced_pkg::t_hexval hv;
        logic              do_ent;
        logic              do_fresh;
        logic [31:0]       acc_mul;

        b        = i_in.in_byte;
        hv       = nced_pkg::hex_value(b);
        do_ent   = 1'b0;
        do_fresh = 1'b0;
        acc_mul  = r_hex ? {r_acc[27:0], 4'b0000}
                         : ({r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0});
        n_mode   = r_mode;
        n_hex    = r_hex;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        plan     = '0;
        fcnt     = '0;
        wr       = 1'b0;

        // sequence state
        case (r_mode)
            nced_pkg::MODE_AMP: begin
                if (b == nced_pkg::CH_HASH) begin
                    n_mode = nced_pkg::MODE_ENT_START;
                    n_hex  = 1'b0;
                    n_acc  = '0;
                    n_cnt  = '0;
                end else begin
                    n_mode = nced_pkg::MODE_IDLE;
                    plan.dir.bytes[plan.dir.cnt] = nced_pkg::CH_AMP;
                    plan.dir.cnt = plan.dir.cnt + 3'd1;
                    do_fresh = 1'b1;
                end
            end
            nced_pkg::MODE_ENT_START: begin
                n_mode = nced_pkg::MODE_ENT;
                if (b == nced_pkg::CH_X_LOWER) begin
                    n_hex = 1'b1;
                end else begin
                    do_ent = 1'b1;
                end
            end
            nced_pkg::MODE_ENT: begin
                do_ent = 1'b1;
            end
            nced_pkg::MODE_ESC0: begin
                if (hv.ok) begin
                    n_acc  = {28'd0, hv.val};
                    n_mode = nced_pkg::MODE_ESC1;
                end else begin
                    n_mode = nced_pkg::MODE_IDLE;
                    n_hex  = 1'b0;
                    n_acc  = '0;
                    n_cnt  = '0;
                    do_fresh = 1'b1;
                end
            end
            nced_pkg::MODE_ESC1: begin
                if (hv.ok) begin
                    plan.dir.bytes[plan.dir.cnt] = {r_acc[3:0], hv.val};
                end else begin
                    plan.dir.bytes[plan.dir.cnt] = r_acc[7:0];
                    do_fresh = 1'b1;
                end
                plan.dir.cnt = plan.dir.cnt + 3'd1;
                n_mode = nced_pkg::MODE_IDLE;
                n_hex  = 1'b0;
                n_acc  = '0;
                n_cnt  = '0;
            end
            default: begin
                n_mode   = nced_pkg::MODE_IDLE;
                do_fresh = 1'b1;
            end
        endcase

        // byte inside an entity
        if (do_ent) begin
            if (hv.ok && r_cnt < CW'(MAX_DIGITS)) begin
                n_acc = acc_mul + {28'd0, hv.val};
                n_cnt = r_cnt + 1'b1;
                wr    = 1'b1;
            end else if (!hv.ok && b == nced_pkg::CH_SEMI) begin
                plan.dir = nced_pkg::utf8_encode(r_acc);
                n_mode   = nced_pkg::MODE_IDLE;
                n_hex    = 1'b0;
                n_acc    = '0;
                n_cnt    = '0;
            end else begin
                plan.flush     = 1'b1;
                plan.flush_hex = r_hex;
                fcnt           = r_cnt;
                n_mode   = nced_pkg::MODE_IDLE;
                n_hex    = 1'b0;
                n_acc    = '0;
                n_cnt    = '0;
                do_fresh = 1'b1;
            end
        end

        // byte with no sequence open
        if (do_fresh) begin
            if (b == nced_pkg::CH_AMP && r_decode_ent) begin
                n_mode = nced_pkg::MODE_AMP;
            end else if (b == nced_pkg::CH_BSLASH && r_escape) begin
                n_mode = nced_pkg::MODE_ESC0;
                n_hex  = 1'b0;
                n_acc  = '0;
                n_cnt  = '0;
            end else begin
                plan.dir.bytes[plan.dir.cnt] = b;
                plan.dir.cnt = plan.dir.cnt + 3'd1;
            end
        end

        // end of text closes whatever is pending
        if (i_in.end_of_text) begin
            case (n_mode)
                nced_pkg::MODE_AMP: begin
                    plan.dir.bytes[plan.dir.cnt] = nced_pkg::CH_AMP;
                    plan.dir.cnt = plan.dir.cnt + 3'd1;
                end
                nced_pkg::MODE_ENT_START, nced_pkg::MODE_ENT: begin
                    plan.flush     = 1'b1;
                    plan.flush_hex = n_hex;
                    fcnt           = n_cnt;
                end
                nced_pkg::MODE_ESC1: begin
                    plan.dir.bytes[plan.dir.cnt] = n_acc[7:0];
                    plan.dir.cnt = plan.dir.cnt + 3'd1;
                end
                default: begin
                end
            endcase
            n_mode = nced_pkg::MODE_IDLE;
            n_hex  = 1'b0;
            n_acc  = '0;
            n_cnt  = '0;
        end
    end

    assign o_load  = beat && (plan.flush || plan.dir.cnt != 3'd0);
    assign o_plan  = plan;
    assign o_fcnt  = fcnt;
    assign o_we    = beat && wr;
    assign o_waddr = r_cnt[AW-1:0];
    assign o_wdata = i_in.in_byte;

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == nced_pkg::MODE_IDLE |-> r_cnt == '0)
        else $error("digits held while idle");

    a_hex_in_entity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hex |-> r_mode == nced_pkg::MODE_ENT)
        else $error("hex flag set outside an entity");

    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> r_cnt < CW'(MAX_DIGITS))
        else $error("digit store written past its depth");

endmodule

### design/nced_emitter.sv
module nced_emitter #(
    parameter int MAX_DIGITS = nced_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  nced_pkg::t_plan                 i_plan,
    input  logic [$clog2(MAX_DIGITS+1)-1:0] i_fcnt,
    input  logic [7:0]                      i_rdata,
    output logic [$clog2(MAX_DIGITS)-1:0]   o_raddr,
    output logic                            o_load_ready,
    nced_out_if.source                      o_out
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int AW = $clog2(MAX_DIGITS);

    logic              r_busy, n_busy;
    nced_pkg::t_ephase r_phase, n_phase;
    nced_pkg::t_plan   r_plan;
    logic [CW-1:0]     r_fcnt;
    logic [CW-1:0]     r_dig, n_dig;
    logic [2:0]        r_di, n_di;

    logic              r_ovalid, n_ovalid;
    logic [7:0]        r_obyte, n_obyte;
    logic              r_olast, n_olast;

    logic              can_push;
    logic              adv;
    logic [7:0]        cur;
    logic              last;
    logic              no_dir;

    assign can_push = !r_ovalid || o_out.ready;
    assign adv      = r_busy && can_push;
    assign no_dir   = r_plan.dir.cnt == 3'd0;

    // walker state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_phase  <= nced_pkg::PH_AMP;
            r_dig    <= '0;
            r_di     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_phase  <= n_phase;
            r_dig    <= n_dig;
            r_di     <= n_di;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_load && o_load_ready) begin
            r_plan <= i_plan;
            r_fcnt <= i_fcnt;
        end
        r_obyte <= n_obyte;
        r_olast <= n_olast;
    end

    // current byte of the run and the walk to the next one
    always_comb begin
        cur     = nced_pkg::CH_AMP;
        last    = 1'b0;
        n_phase = r_phase;
        n_dig   = r_dig;
        n_di    = r_di;
        n_busy  = r_busy;

        case (r_phase)
            nced_pkg::PH_AMP: begin
                cur  = nced_pkg::CH_AMP;
                last = !r_plan.flush_hex && r_fcnt == '0 && no_dir;
                if (adv) begin
                    n_phase = r_plan.flush_hex ? nced_pkg::PH_X
                            : (r_fcnt != '0) ? nced_pkg::PH_DIG : nced_pkg::PH_DIR;
                end
            end
            nced_pkg::PH_X: begin
                cur  = nced_pkg::CH_X_LOWER;
                last = r_fcnt == '0 && no_dir;
                if (adv) begin
                    n_phase = (r_fcnt != '0) ? nced_pkg::PH_DIG : nced_pkg::PH_DIR;
                end
            end
            nced_pkg::PH_DIG: begin
                cur  = i_rdata;
                last = (r_dig + 1'b1) == r_fcnt && no_dir;
                if (adv) begin
                    n_dig = r_dig + 1'b1;
                    if ((r_dig + 1'b1) == r_fcnt) begin
                        n_phase = nced_pkg::PH_DIR;
                    end
                end
            end
            nced_pkg::PH_DIR: begin
                cur  = r_plan.dir.bytes[r_di];
                last = (r_di + 3'd1) == r_plan.dir.cnt;
                if (adv) begin
                    n_di = r_di + 3'd1;
                end
            end
            default: begin
                cur  = nced_pkg::CH_AMP;
                last = 1'b1;
            end
        endcase

        if (adv && last) begin
            n_busy = 1'b0;
        end

        o_load_ready = !r_busy || (adv && last);

        // a new run starts from its first byte
        if (i_load && o_load_ready) begin
            n_busy  = 1'b1;
            n_phase = i_plan.flush ? nced_pkg::PH_AMP : nced_pkg::PH_DIR;
            n_dig   = '0;
            n_di    = '0;
        end

        n_ovalid = r_ovalid && !o_out.ready;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        if (adv) begin
            n_ovalid = 1'b1;
            n_obyte  = cur;
            n_olast  = last;
        end
    end

    // address from the next-state digit index so the registered read lines up with the digit
    assign o_raddr = n_dig[AW-1:0];

    assign o_out.valid    = r_ovalid;
    assign o_out.out_byte = r_obyte;
    assign o_out.run_last = r_olast;

    a_dig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_phase == nced_pkg::PH_DIG |-> r_dig < r_fcnt)
        else $error("digit index past held count");

    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_phase == nced_pkg::PH_DIR |-> r_di < r_plan.dir.cnt)
        else $error("plain byte index past run length");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && last && !i_load |=> !r_busy && r_ovalid && r_olast)
        else $error("run did not close on its last byte");

endmodule

### design/numeric_entity_escape_decoder.sv
// Numeric entity and backslash escape decoder for a text byte stream.
// i_in carries one text byte per beat with end_of_text on the last byte of a
// string; o_out carries decoded bytes, run_last marking the final byte that an
// input beat caused (a beat may cause none). i_cfg writes decode_entities
// (index 0) and escape_codes (index 1); it is always ready and must only be
// used while the block is idle.
// The plan of a taken beat is registered in the emitter; its bytes then move
// through the output register onto o_out. Throughput: one input beat per cycle
// while each beat causes at most one output byte and the receiver does not
// stall. A beat that causes several bytes puts them out one at a time; the input
// is taken again in the cycle that the last of them moves into the output
// register. Held entity digits sit in a small RAM and are replayed from it on
// failure. Reset (synchronous, active low) clears both registers, the parse
// state and the output valid flag; no clearing pass is needed. When the receiver
// stalls, the output register holds its byte and the input backs up behind it.
module numeric_entity_escape_decoder #(
    parameter int MAX_DIGITS = nced_pkg::MAX_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nced_in_if.sink    i_in,
    nced_out_if.source o_out,
    nced_cfg_if.sink   i_cfg
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int AW = $clog2(MAX_DIGITS);

    logic            load;
    logic            load_ready;
    nced_pkg::t_plan plan;
    logic [CW-1:0]   fcnt;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [7:0]      wdata;
    logic [AW-1:0]   raddr;
    logic [7:0]      rdata;

    // parse state, registers and per-beat plan
    nced_parser #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .i_load_ready (load_ready),
        .o_load       (load),
        .o_plan       (plan),
        .o_fcnt       (fcnt),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata)
    );

    // held entity digits
    nced_ram #(
        .WIDTH (8),
        .DEPTH (MAX_DIGITS)
    ) u_held (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // byte run walker and output register
    nced_emitter #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emitter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_plan       (plan),
        .i_fcnt       (fcnt),
        .i_rdata      (rdata),
        .o_raddr      (raddr),
        .o_load_ready (load_ready),
        .o_out        (o_out)
    );

endmodule
